@@ rtl/xks_pkg.sv @@
// ----------------------------------------------------------------------------
// xks_pkg
// Shared sizes, constants, state and bus types for the keystream decryptor.
// ----------------------------------------------------------------------------
package xks_pkg;

  localparam int KEY_WORDS     = 1024;
  localparam int FULL_WORDS    = 512;
  localparam int STRIDE        = 64;
  localparam int CHECK_WORDS   = 128;
  localparam int ROUNDS        = 6;
  localparam int NUM_KEY_PARTS = 4;

  localparam int KA_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int POS_MAX = (FULL_WORDS > CHECK_WORDS) ? FULL_WORDS : CHECK_WORDS;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int PH_W    = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [31:0] DELTA_WORD = 32'h9e37_79b9;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_MIX,
    ST_EXP_WR,
    ST_KEY_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic            we;
    logic [KA_W-1:0] waddr;
    logic [31:0]     wdata;
    logic [KA_W-1:0] raddr_a;
    logic [KA_W-1:0] raddr_b;
  } ram_req_t;

endpackage

@@ rtl/xks_if.sv @@
// ----------------------------------------------------------------------------
// xks_if
// Valid/ready channels: cipher words in, plain words out, register writes.
// ----------------------------------------------------------------------------
interface xks_cipher_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic        last_word;
  modport source (output valid, output cipher_word, output last_word, input ready);
  modport sink   (input valid, input cipher_word, input last_word, output ready);
endinterface

interface xks_plain_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word;
  logic [31:0] running_checksum;
  logic        buffer_end;
  modport source (output valid, output plain_word, output running_checksum,
                  output buffer_end, input ready);
  modport sink   (input valid, input plain_word, input running_checksum,
                  input buffer_end, output ready);
endinterface

interface xks_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/xks_key_ram.sv @@
// ----------------------------------------------------------------------------
// xks_key_ram
// Expanded key store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module xks_key_ram (
  input  logic              clk,
  input  xks_pkg::ram_req_t req,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);
  import xks_pkg::*;

  logic [31:0] mem [KEY_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

@@ rtl/xks_mix_unit.sv @@
// ----------------------------------------------------------------------------
// xks_mix_unit
// XXTEA mixing step, two halves registered, then added onto the old word.
// ----------------------------------------------------------------------------
module xks_mix_unit (
  input  logic        clk,
  input  logic [31:0] y,
  input  logic [31:0] z,
  input  logic [31:0] sum,
  input  logic [31:0] k,
  input  logic [31:0] old,
  output logic [31:0] result
);
  import xks_pkg::*;

  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] old_r;

  always_ff @(posedge clk) begin
    a_r   <= ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b_r   <= (sum ^ y) + (k ^ z);
    old_r <= old;
  end

  assign result = old_r + (a_r ^ b_r);

endmodule

@@ rtl/xxtea_keystream_word_decrypt.sv @@
// ----------------------------------------------------------------------------
// xxtea_keystream_word_decrypt
// Keystream word decryptor with on-demand XXTEA expansion of a long key.
// ----------------------------------------------------------------------------
// One cipher beat is taken at a time. If the key changed since the last
// expansion, the beat first triggers an in-place expansion of the 1024-word
// key store: six rounds, each step a read of two store words, one pass
// through the shared mix unit and a write back. After that each beat goes
// through accept, a single read of the key store and the result load; a
// stalled result beat holds the block in its last step. The key store
// starts as zeros without a clearing pass: until the first round after
// reset has written it, reads of unwritten words are forced to zero. Key
// writes are always accepted; a write of a new value forces the next beat
// to expand again.
// ----------------------------------------------------------------------------
module xxtea_keystream_word_decrypt (
  input logic clk,
  input logic rst,
  xks_cfg_if.sink    cfg,
  xks_cipher_if.sink cipher,
  xks_plain_if.source plain
);
  import xks_pkg::*;

  localparam logic [KA_W-1:0]  KA_LAST   = KA_W'(KEY_WORDS - 1);
  localparam logic [PH_W-1:0]  PH_LAST   = PH_W'(STRIDE - 1);
  localparam logic [RND_W-1:0] RND_LAST  = RND_W'(ROUNDS - 1);
  localparam logic [POS_W-1:0] POS_FULL  = POS_W'(FULL_WORDS);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'(CHECK_WORDS);

  state_t state;
  state_t state_next;

  // key and expansion state
  logic [31:0]      key_part [NUM_KEY_PARTS];
  logic             key_ready;
  logic             store_init;   // first round after reset has written the store
  logic [31:0]      z;            // last word written, i.e. store[last] between runs
  logic [31:0]      sum;
  logic [31:0]      sum_next;
  logic [KA_W-1:0]  p;
  logic [RND_W-1:0] round;

  // buffer position state
  logic [POS_W-1:0] word_position;
  logic [PH_W-1:0]  stride_phase;
  logic [KA_W-1:0]  key_pointer;
  logic [31:0]      checksum_acc;

  // held beat and result register
  logic [31:0] word_r;
  logic        last_r;
  logic        out_valid;
  logic [31:0] out_word;
  logic [31:0] out_check;
  logic        out_end;

  ram_req_t    ram_req;
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;
  logic [31:0] mix_y;
  logic [31:0] mix_old;
  logic [31:0] mix_k;
  logic [31:0] mix_res;
  logic        virgin;

  logic        in_accept;
  logic        out_free;
  logic        exp_last_step;
  logic        key_change;
  logic        use_key;
  logic [31:0] plain_val;
  logic [KA_W-1:0] kptr_inc;

  assign in_accept     = cipher.valid && cipher.ready;
  assign out_free      = !out_valid || plain.ready;
  assign exp_last_step = (p == KA_LAST) && (round == RND_LAST);

  // a write to a key part with a new value
  assign key_change = cfg.valid && cfg.ready && (cfg.index <= REG_KEY_PART_3) &&
                      (key_part[2'(cfg.index)] != cfg.data);

  // --- key store and shared mix unit ---
  xks_key_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // untouched words read as zero during the first round after reset;
  // the last step of that round reads word 0, already written
  assign virgin  = !store_init && (round == '0);
  assign mix_y   = (virgin && (p != KA_LAST)) ? 32'h0 : rdata_b;
  assign mix_old = virgin ? 32'h0 : rdata_a;
  assign mix_k   = key_part[2'(p) ^ sum[3:2]];

  xks_mix_unit u_mix (
    .clk    (clk),
    .y      (mix_y),
    .z      (z),
    .sum    (sum),
    .k      (mix_k),
    .old    (mix_old),
    .result (mix_res)
  );

  assign sum_next = ((state == ST_IDLE) ? 32'h0 : sum) + DELTA_WORD;

  // --- next state ---
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = key_ready ? ST_KEY_RD : ST_EXP_RD;
        end
      end
      ST_EXP_RD:  state_next = ST_EXP_MIX;
      ST_EXP_MIX: state_next = ST_EXP_WR;
      ST_EXP_WR: begin
        state_next = exp_last_step ? ST_KEY_RD : ST_EXP_RD;
      end
      ST_KEY_RD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --- outputs of the sequencer ---
  always_comb begin
    ram_req.we      = 1'b0;
    ram_req.waddr   = p;
    ram_req.wdata   = mix_res;
    ram_req.raddr_a = p;
    ram_req.raddr_b = (p == KA_LAST) ? '0 : p + 1'b1;
    cipher.ready    = 1'b0;
    unique case (state)
      ST_IDLE:    cipher.ready = 1'b1;
      ST_EXP_RD:  ;
      ST_EXP_MIX: ;
      ST_EXP_WR:  ram_req.we = 1'b1;
      ST_KEY_RD:  ram_req.raddr_a = key_pointer;
      ST_EMIT:    ram_req.raddr_a = key_pointer;
      default:    ;
    endcase
  end

  assign cfg.ready = 1'b1;

  // --- word path ---
  assign use_key   = (word_position < POS_FULL) || (stride_phase == '0);
  assign plain_val = word_r ^ (use_key ? rdata_a : 32'h0);
  assign kptr_inc  = (key_pointer == KA_LAST) ? '0 : key_pointer + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_ready     <= 1'b0;
      store_init    <= 1'b0;
      z             <= 32'h0;
      word_position <= '0;
      stride_phase  <= '0;
      key_pointer   <= '0;
      checksum_acc  <= 32'h0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_KEY_PARTS; i++) begin
        key_part[i] <= 32'h0;
      end
    end else begin
      state <= state_next;

      if (state == ST_EXP_WR) begin
        z <= mix_res;
        if (exp_last_step) begin
          store_init <= 1'b1;
        end
      end

      // a changed key part forces a fresh expansion on the next beat
      if (key_change) begin
        key_ready <= 1'b0;
      end else if ((state == ST_EXP_WR) && exp_last_step) begin
        key_ready <= 1'b1;
      end

      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end

      if ((state == ST_EMIT) && out_free) begin
        if (last_r) begin
          word_position <= '0;
          stride_phase  <= '0;
          key_pointer   <= '0;
          checksum_acc  <= 32'h0;
        end else begin
          if (use_key) begin
            key_pointer <= kptr_inc;
          end
          if (word_position >= POS_FULL) begin
            stride_phase <= (stride_phase == PH_LAST) ? '0 : stride_phase + 1'b1;
          end
          if (word_position < POS_CHECK) begin
            checksum_acc <= checksum_acc ^ plain_val;
          end
          if ((word_position < POS_FULL) || (word_position < POS_CHECK)) begin
            word_position <= word_position + 1'b1;
          end
        end
      end

      if (key_change) begin
        key_part[2'(cfg.index)] <= cfg.data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      word_r <= cipher.cipher_word;
      last_r <= cipher.last_word;
    end
    if (state == ST_EXP_WR) begin
      if (p == KA_LAST) begin
        p <= '0;
        if (!exp_last_step) begin
          round <= round + 1'b1;
          sum   <= sum_next;
        end
      end else begin
        p <= p + 1'b1;
      end
    end else if (in_accept) begin
      p     <= '0;
      round <= '0;
      sum   <= sum_next;
    end
    if ((state == ST_EMIT) && out_free) begin
      out_word  <= plain_val;
      out_check <= (word_position < POS_CHECK) ? (checksum_acc ^ plain_val) : checksum_acc;
      out_end   <= last_r;
    end
  end

  assign plain.valid            = out_valid;
  assign plain.plain_word       = out_word;
  assign plain.running_checksum = out_check;
  assign plain.buffer_end       = out_end;

endmodule

@@ rtl/xks_checker.sv @@
// ----------------------------------------------------------------------------
// xks_checker
// Port-level checks on the decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module xks_checker (
  input logic        clk,
  input logic        rst,
  input logic        cipher_valid,
  input logic        cipher_ready,
  input logic        plain_valid,
  input logic        plain_ready,
  input logic [31:0] plain_word,
  input logic [31:0] running_checksum,
  input logic        buffer_end
);

  logic first_of_buffer;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_of_buffer <= 1'b1;
    end else if (plain_valid && plain_ready) begin
      first_of_buffer <= buffer_end;
    end
  end

  // one beat at a time: taking a word closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cipher_valid && cipher_ready) |=> !cipher_ready)
    else $error("cipher beat taken while a word is in flight");

  // the first word of a buffer always counts towards the checksum
  a_first_checksum: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && first_of_buffer) |-> (running_checksum == plain_word))
    else $error("checksum does not restart at buffer start");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && !plain_ready) |=>
      (plain_valid && $stable(plain_word) && $stable(running_checksum)
       && $stable(buffer_end)))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !plain_valid)
    else $error("result beat pending after reset");

endmodule

bind xxtea_keystream_word_decrypt xks_checker u_xks_checker (
  .clk              (clk),
  .rst              (rst),
  .cipher_valid     (cipher.valid),
  .cipher_ready     (cipher.ready),
  .plain_valid      (plain.valid),
  .plain_ready      (plain.ready),
  .plain_word       (plain.plain_word),
  .running_checksum (plain.running_checksum),
  .buffer_end       (plain.buffer_end)
);

@@ tb/xxtea_keystream_word_decrypt_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xxtea_keystream_word_decrypt_tb
// Self-checking bench for the keystream word decryptor. A cycle-free copy of
// the key expansion and the per-word XOR schedule predicts every plain beat.
// Stimulus covers directed key and buffer cases, one buffer long enough to
// reach the strided section, and random phases, most with a new key.
// ---------------------------------------------------------------------------
module xxtea_keystream_word_decrypt_tb;
  import xks_pkg::*;

  localparam int IDLE_PCT      = 29;
  localparam int MAX_REPORTS   = 10;
  // No beat is taken during a key expansion; this limit is well above its length.
  localparam int STALL_LIMIT   = 100_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS   = 115;
  // Runs through the full section and a few strides into the strided one.
  localparam int LONG_BEATS    = FULL_WORDS + 2 * STRIDE + 3;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam int MAX_REG_INDEX = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic [31:0] plain_word;
    logic [31:0] running_checksum;
    logic        buffer_end;
  } plain_beat_t;

  logic clk = 1'b0;
  logic rst;

  xks_cfg_if    cfg_bus ();
  xks_cipher_if cipher_bus ();
  xks_plain_if  plain_bus ();

  xxtea_keystream_word_decrypt dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .cipher (cipher_bus),
    .plain  (plain_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's state, as left by reset.
  logic [31:0] key_held [NUM_KEY_PARTS] = '{default: '0};
  logic [31:0] long_key [KEY_WORDS]     = '{default: '0};
  bit          key_expanded    = 1'b0;
  int          buf_pos         = 0;
  int          stride_pos      = 0;
  int          key_ptr         = 0;
  logic [31:0] checksum_so_far = '0;

  plain_beat_t expected_plain [$];
  plain_beat_t want_beat;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  bit          idling_on      = 1'b1;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // XXTEA mixing term for one store word
  function automatic logic [31:0] xxtea_mx(input logic [31:0] y, input logic [31:0] z,
                                           input logic [31:0] sum, input int p,
                                           input logic [1:0] e);
    logic [31:0] a;
    logic [31:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (key_held[p[1:0] ^ e] ^ z);
    return a ^ b;
  endfunction

  // In-place rounds over the store as it stands; z carries across rounds.
  function automatic void expand_long_key();
    logic [31:0] sum;
    logic [31:0] z;
    logic [1:0]  e;
    sum = '0;
    z   = long_key[KEY_WORDS-1];
    for (int r = 0; r < ROUNDS; r++) begin
      sum = sum + DELTA_WORD;
      e   = sum[3:2];
      for (int p = 0; p < KEY_WORDS - 1; p++) begin
        long_key[p] = long_key[p] + xxtea_mx(long_key[p+1], z, sum, p, e);
        z = long_key[p];
      end
      long_key[KEY_WORDS-1] = long_key[KEY_WORDS-1]
                              + xxtea_mx(long_key[0], z, sum, KEY_WORDS - 1, e);
      z = long_key[KEY_WORDS-1];
    end
    key_expanded = 1'b1;
  endfunction

  function automatic logic [31:0] take_key_word();
    logic [31:0] k;
    k = long_key[key_ptr];
    key_ptr = (key_ptr + 1) % KEY_WORDS;
    return k;
  endfunction

  // Works out the plain beat for one accepted cipher beat and queues it.
  function automatic void compute_plain_beat(input logic [31:0] w, input logic l);
    logic [31:0] pw;
    plain_beat_t beat;
    if (!key_expanded)
      expand_long_key();
    pw = w;
    if (buf_pos < FULL_WORDS) begin
      pw = w ^ take_key_word();
    end else begin
      // strided section: only the first word of each stride is keyed
      if (stride_pos == 0)
        pw = w ^ take_key_word();
      stride_pos = (stride_pos + 1) % STRIDE;
    end
    if (buf_pos < CHECK_WORDS)
      checksum_so_far = checksum_so_far ^ pw;
    beat.plain_word       = pw;
    beat.running_checksum = checksum_so_far;
    beat.buffer_end       = l;
    expected_plain.push_back(beat);
    // position saturates once past both windows
    if (buf_pos < POS_MAX)
      buf_pos++;
    if (l) begin
      // key store and key state survive the end of a buffer
      buf_pos         = 0;
      stride_pos      = 0;
      key_ptr         = 0;
      checksum_so_far = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: expected %08h, got %08h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && plain_bus.valid && plain_bus.ready) begin
      if (expected_plain.size() == 0) begin
        flag_mismatch("plain beat with nothing expected", '0, plain_bus.plain_word);
      end else begin
        want_beat = expected_plain.pop_front();
        if (plain_bus.plain_word !== want_beat.plain_word)
          flag_mismatch("plain_word", want_beat.plain_word, plain_bus.plain_word);
        if (plain_bus.running_checksum !== want_beat.running_checksum)
          flag_mismatch("running_checksum", want_beat.running_checksum,
                        plain_bus.running_checksum);
        if (plain_bus.buffer_end !== want_beat.buffer_end)
          flag_mismatch("buffer_end", 32'(want_beat.buffer_end),
                        32'(plain_bus.buffer_end));
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((cfg_bus.valid && cfg_bus.ready) || (cipher_bus.valid && cipher_bus.ready) ||
        (plain_bus.valid && plain_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk)
    plain_bus.ready = !(idling_on && ($urandom_range(99) < IDLE_PCT));

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [CFG_IDX_W-1:0] key_reg(input int part);
    case (part)
      0:       return REG_KEY_PART_0;
      1:       return REG_KEY_PART_1;
      2:       return REG_KEY_PART_2;
      default: return REG_KEY_PART_3;
    endcase
  endfunction

  function automatic logic [31:0] rand_cipher_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // One register write; only called with the block idle.
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    // out-of-range indexes are dropped; an unchanged value keeps the expansion
    if (idx < NUM_KEY_PARTS && key_held[idx] != val) begin
      key_held[idx] = val;
      key_expanded  = 1'b0;
    end
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic load_key(input logic [127:0] key);
    for (int i = 0; i < NUM_KEY_PARTS; i++)
      write_key_reg(key_reg(i), key[32*i +: 32]);
  endtask

  // Sends one cipher beat; valid stays high into the next beat unless a gap falls.
  task automatic send_word(input logic [31:0] w, input logic l);
    @(negedge clk);
    while (idling_on && ($urandom_range(99) < IDLE_PCT)) begin
      cipher_bus.valid = 1'b0;
      @(negedge clk);
    end
    cipher_bus.valid       = 1'b1;
    cipher_bus.cipher_word = w;
    cipher_bus.last_word   = l;
    do @(posedge clk); while (!cipher_bus.ready);
    compute_plain_beat(w, l);
  endtask

  task automatic drain_results();
    @(negedge clk);
    cipher_bus.valid = 1'b0;
    while (expected_plain.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No key written: expansion runs with the all-zero key over a zero store.
  task automatic test_reset_key();
    send_word('0, 1'b0);
    send_word(ALL_ONES, 1'b0);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    drain_results();
  endtask

  // Key extremes, single-beat buffer, rewrite of an unchanged key and a key
  // change in the middle of a buffer.
  task automatic test_key_extremes();
    load_key({4{ALL_ONES}});
    send_word(ALL_ONES, 1'b1);
    send_word('0, 1'b0);
    send_word($urandom, 1'b0);
    send_word(ALL_ONES, 1'b1);
    drain_results();
    load_key({4{ALL_ONES}});
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    drain_results();
    load_key('0);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    drain_results();
  endtask

  // Writes outside the key registers must leave the key alone.
  task automatic test_ignored_index();
    write_key_reg(CFG_IDX_W'(NUM_KEY_PARTS), ALL_ONES);
    write_key_reg(CFG_IDX_W'(MAX_REG_INDEX), $urandom);
    write_key_reg(CFG_IDX_W'($urandom_range(MAX_REG_INDEX - 1, NUM_KEY_PARTS + 1)), $urandom);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    drain_results();
  endtask

  // One long buffer at full rate: checksum window, saturation of the position
  // and strided keying.
  task automatic test_long_buffer();
    idling_on = 1'b0;
    load_key({$urandom, $urandom, $urandom, $urandom});
    for (int i = 0; i < LONG_BEATS; i++)
      send_word($urandom, i == LONG_BEATS - 1);
    drain_results();
    idling_on = 1'b1;
  endtask

  // Random phases, most under a fresh key setting; one only writes an unused index.
  // Buffers are mostly short; longer picks are cut off by the beat budget. Phases
  // end wherever that budget runs out, so keys also change mid-buffer.
  task automatic test_random_buffers();
    logic [127:0] key;
    int sent;
    int len;
    int pick;
    key = {$urandom, $urandom, $urandom, $urandom};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1: key = '0;
        2: key = {4{ALL_ONES}};
        3: write_key_reg(CFG_IDX_W'($urandom_range(MAX_REG_INDEX, NUM_KEY_PARTS)),
                         $urandom);
        4: begin
          pick = $urandom_range(NUM_KEY_PARTS - 1);
          key[32*pick +: 32] = $urandom;
        end
        default: key = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_key(key);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 70)
          len = $urandom_range(16, 1);
        else if (pick < 90)
          len = $urandom_range(CHECK_WORDS + 32, CHECK_WORDS - 8);
        else
          len = $urandom_range(FULL_WORDS + 2 * STRIDE, FULL_WORDS - 4);
        for (int i = 0; i < len && sent < PHASE_BEATS; i++) begin
          // occasional early end flag breaks a buffer short
          send_word(rand_cipher_word(), (i == len - 1) || ($urandom_range(99) < 2));
          sent++;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    cipher_bus.valid       = 1'b0;
    cipher_bus.cipher_word = '0;
    cipher_bus.last_word   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_key();
    test_key_extremes();
    test_ignored_index();
    test_long_buffer();
    test_random_buffers();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_plain.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
